@@ src/dmkt_pkg.sv @@
// ----------------------------------------------------------------------------
// dmkt_pkg
// Shared widths, codes and word types of the direct-mapped key table.
// ----------------------------------------------------------------------------
package dmkt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned KEY_W             = 64;
  localparam int unsigned PAYLOAD_W         = 64;
  localparam int unsigned CNT_W             = 32;

  // residue unit: key bits folded in per cycle, and steps per key
  localparam int unsigned REDUCE_BITS  = 8;
  localparam int unsigned REDUCE_STEPS = KEY_W / REDUCE_BITS;
  localparam int unsigned REDUCE_CNT_W = $clog2(REDUCE_STEPS);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic                 mode;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } req_word_t;

  typedef struct packed {
    logic                 hit;
    logic [PAYLOAD_W-1:0] payload_out;
    logic                 replaced;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    logic [CNT_W-1:0]     collision_count;
  } rsp_word_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } slot_t;

endpackage

@@ src/dmkt_index.sv @@
// ----------------------------------------------------------------------------
// dmkt_index
// Slot index from a 64-bit key: key modulo the table size. A power-of-two
// size takes the low bits; any other size runs a shift-and-subtract residue
// over the key, most significant bits first.
// ----------------------------------------------------------------------------
module dmkt_index #(
  parameter int unsigned TABLE_ENTRIES = dmkt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dmkt_pkg::KEY_W-1:0] key,
  output logic [IDX_W-1:0]           idx,
  output logic                       idx_valid
);
  import dmkt_pkg::*;

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (start) begin
          idx <= key[IDX_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          idx_valid <= 1'b0;
        end else begin
          idx_valid <= start;
        end
      end
    end else begin : g_residue
      localparam logic [IDX_W:0] ENT = TABLE_ENTRIES[IDX_W:0];

      logic [KEY_W-1:0]        kreg;
      logic [IDX_W-1:0]        rem;
      logic [IDX_W-1:0]        rem_next;
      logic [REDUCE_CNT_W-1:0] cnt;
      logic                    busy;
      logic                    done;

      // remainder stays below the size, so each doubled step needs one subtract
      always_comb begin
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] r;
        r = rem;
        for (int i = 0; i < REDUCE_BITS; i++) begin
          t = {r, kreg[KEY_W-1-i]};
          if (t >= ENT) begin
            t = t - ENT;
          end
          r = t[IDX_W-1:0];
        end
        rem_next = r;
      end

      always_ff @(posedge clk) begin
        if (start) begin
          kreg <= key;
          rem  <= '0;
        end else if (busy) begin
          kreg <= kreg << REDUCE_BITS;
          rem  <= rem_next;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else if (start) begin
          busy <= 1'b1;
          done <= 1'b0;
          cnt  <= '0;
        end else if (busy) begin
          cnt <= cnt + 1'b1;
          if (cnt == REDUCE_CNT_W'(REDUCE_STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          done <= 1'b0;
        end
      end

      assign idx       = rem;
      assign idx_valid = done;
    end
  endgenerate

endmodule

@@ src/dmkt_table.sv @@
// ----------------------------------------------------------------------------
// dmkt_table
// Slot memory: valid bit, full key and payload per entry, one write and one
// registered read per cycle. After reset a sweep clears every valid bit.
// ----------------------------------------------------------------------------
module dmkt_table #(
  parameter int unsigned TABLE_ENTRIES = dmkt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  output dmkt_pkg::slot_t       rd_data,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  dmkt_pkg::slot_t       wr_data,
  output logic                  clearing
);
  import dmkt_pkg::*;

  slot_t            mem [TABLE_ENTRIES];
  logic [IDX_W-1:0] clr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == IDX_W'(TABLE_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

@@ src/direct_mapped_key_table_core.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_key_table_core
// Direct-mapped hash table with full-key check and saturating statistics.
// ----------------------------------------------------------------------------
// One request word (lookup or insert) is in flight at a time; the response
// register lets the next request enter while a response waits. With a
// power-of-two TABLE_ENTRIES a request passes S_INDEX, where the registered
// slot index presents the memory read, then S_EVAL, which compares, writes
// back and loads the response, waiting there while a stalled response holds
// the register. Any other size adds the residue unit, which folds 8 key bits
// per cycle, ahead of the memory read. After reset the block sweeps the slot
// memory to clear its valid bits and stalls requests until the sweep is done.
module direct_mapped_key_table_core #(
  parameter int unsigned TABLE_ENTRIES = dmkt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dmkt_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dmkt_pkg::rsp_word_t rsp
);
  import dmkt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_INDEX = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

  state_t               state, state_next;
  req_word_t            cur;
  logic [IDX_W-1:0]     slot_idx;
  logic [IDX_W-1:0]     idx;
  logic                 idx_valid;
  slot_t                rd_data;
  slot_t                wr_data;
  logic                 clearing;
  logic                 req_acc;
  logic                 eval_go;
  logic                 rd_en;
  logic                 wr_en;
  logic                 match;
  logic [CNT_W-1:0]     hits_total, misses_total, collisions_total;
  logic [CNT_W-1:0]     hits_next, misses_next, collisions_next;
  rsp_word_t            rsp_next;

  assign eval_go   = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) || (state == S_EVAL && eval_go));
  assign req_acc   = req_valid && !req_stall;

  dmkt_index #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_index (
    .clk       (clk),
    .rst       (rst),
    .start     (req_acc),
    .key       (req.key),
    .idx       (idx),
    .idx_valid (idx_valid)
  );

  assign rd_en = (state == S_INDEX) && idx_valid;
  assign wr_en = (state == S_EVAL) && eval_go && (cur.mode == MODE_INSERT);
  assign wr_data = '{valid: 1'b1, key: cur.key, payload: cur.payload};

  dmkt_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_idx   (idx),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_idx   (slot_idx),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (!clearing) state_next = S_IDLE;
      S_IDLE:  if (req_acc) state_next = S_INDEX;
      S_INDEX: if (idx_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (req_acc) begin
          state_next = S_INDEX;
        end else if (eval_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // compare and count on the slot word read in S_INDEX
  always_comb begin
    match           = rd_data.valid && (rd_data.key == cur.key);
    hits_next       = hits_total;
    misses_next     = misses_total;
    collisions_next = collisions_total;
    rsp_next        = '0;
    if (cur.mode == MODE_LOOKUP) begin
      if (match) begin
        rsp_next.hit         = 1'b1;
        rsp_next.payload_out = rd_data.payload;
        if (hits_total != CNT_MAX) hits_next = hits_total + 1'b1;
      end else begin
        if (misses_total != CNT_MAX) misses_next = misses_total + 1'b1;
      end
    end else begin
      if (rd_data.valid) begin
        rsp_next.replaced = 1'b1;
        if (collisions_total != CNT_MAX) collisions_next = collisions_total + 1'b1;
      end
    end
    rsp_next.hit_count       = hits_next;
    rsp_next.miss_count      = misses_next;
    rsp_next.collision_count = collisions_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      rsp_valid        <= 1'b0;
      hits_total       <= '0;
      misses_total     <= '0;
      collisions_total <= '0;
    end else begin
      state <= state_next;
      if (state == S_EVAL && eval_go) begin
        rsp_valid        <= 1'b1;
        hits_total       <= hits_next;
        misses_total     <= misses_next;
        collisions_total <= collisions_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      cur <= req;
    end
    if (rd_en) begin
      slot_idx <= idx;
    end
    if (state == S_EVAL && eval_go) begin
      rsp <= rsp_next;
    end
  end

endmodule
